/* hw/rtl/mjw_pkg.sv */
// ----------------------------------------------------------------------------
// mjw_pkg
// Shared types and constants for the minimum-jerk waypoint unit.
// ----------------------------------------------------------------------------
package mjw_pkg;

  localparam int unsigned NumStages = 9;

  localparam logic [7:0]  MaxSteps    = 8'd255;
  localparam logic [7:0]  NumStepsRst = 8'd40;
  localparam logic [16:0] TOne        = 17'd65536;
  localparam logic [20:0] PBase       = 21'd655360;

  typedef logic signed [15:0] angle_t;

  typedef struct packed {
    logic [NumStages-1:0] take;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

endpackage

/* hw/rtl/mjw_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// mjw_pipe_ctrl
// Valid bits and per-stage load enables for the evaluator pipeline; empty
// stages fill even while the output beat is stalled.
// ----------------------------------------------------------------------------
module mjw_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output mjw_pkg::pipe_ctrl_t ctrl_o
);
  import mjw_pkg::*;

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] load;
  logic [NumStages-1:0] take;

  always_comb begin
    load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  always_comb begin
    take[0] = load[0] && in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      take[k] = load[k] && valid_q[k-1];
    end
  end

  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o   = !load[0];
  assign ctrl_o.take  = take;
  assign ctrl_o.valid = valid_q;

endmodule

/* hw/rtl/min_jerk_waypoint_unit.sv */
// ----------------------------------------------------------------------------
// min_jerk_waypoint_unit
// Minimum-jerk (quintic) waypoint evaluator: t = index/steps,
// s = 10t^3 - 15t^4 + 6t^5, position = start + (goal - start) * s, saturated.
//
//   channel  | signals                                    | direction
//   ---------+--------------------------------------------+----------
//   input    | in_valid_i, in_stall_o, start_pos_i,       | in
//            | goal_pos_i, waypoint_index_i               |
//   output   | out_valid_o, out_stall_i, position_o       | out
//   config   | cfg_we_i, cfg_wdata_i (num_steps)          | in
//
// nine register stages: an input stage that clamps the index, three for the
// radix-2 division index/steps, one multiplier each for t^2, t^3, s and the
// angle scale, and a final round, add and saturate into the output register.
// one beat per cycle while the output is not stalled; a result is offered once
// its beat has reached the output register; a stalled output holds its beat and
// earlier stages keep filling until the pipeline is full.
// reset clears all valid bits and sets num_steps to 40.
// ----------------------------------------------------------------------------
module min_jerk_waypoint_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  mjw_pkg::angle_t start_pos_i,
  input  mjw_pkg::angle_t goal_pos_i,
  input  logic [7:0]      waypoint_index_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mjw_pkg::angle_t position_o
);
  import mjw_pkg::*;

  function automatic logic [9:0] div_step(input logic [8:0] rem, input logic b,
                                          input logic [8:0] dvs);
    logic [9:0] rr;
    rr = {rem, b};
    if (rr >= {1'b0, dvs}) begin
      return {1'b1, 9'(rr - {1'b0, dvs})};
    end else begin
      return {1'b0, rr[8:0]};
    end
  endfunction

  pipe_ctrl_t ctrl;

  mjw_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .in_stall_o (in_stall_o),
    .ctrl_o     (ctrl)
  );

  // config register
  logic [7:0] num_steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_steps_q <= NumStepsRst;
    end else if (cfg_we_i) begin
      num_steps_q <= cfg_wdata_i;
    end
  end

  // stage 1: clamp index, set up divider
  logic [7:0]         n_eff, idx_c;
  angle_t             s1_start_q;
  logic signed [16:0] s1_diff_q, s1_diff_d;
  logic [8:0]         s1_rem_q, s1_div_q;
  logic               s1_nz_q;

  assign n_eff     = (num_steps_q > MaxSteps) ? MaxSteps : num_steps_q;
  assign idx_c     = (waypoint_index_i > n_eff) ? n_eff : waypoint_index_i;
  assign s1_diff_d = 17'(goal_pos_i) - 17'(start_pos_i);

  always_ff @(posedge clk_i) begin
    if (ctrl.take[0]) begin
      s1_start_q <= start_pos_i;
      s1_diff_q  <= s1_diff_d;
      s1_rem_q   <= {1'b0, idx_c};
      s1_div_q   <= {n_eff, 1'b0};
      s1_nz_q    <= (n_eff != 8'd0);
    end
  end

  // stage 2: quotient bits 16..11
  logic [16:0] s1_xb;
  logic [8:0]  s2_rem_d;
  logic [5:0]  s2_quo_d;
  logic [9:0]  s2_step;

  assign s1_xb = {9'd0, s1_div_q[8:1]};

  always_comb begin
    s2_rem_d = s1_rem_q;
    s2_quo_d = '0;
    s2_step  = '0;
    for (int i = 0; i < 6; i++) begin
      s2_step     = div_step(s2_rem_d, s1_xb[16-i], s1_div_q);
      s2_quo_d[5-i] = s2_step[9];
      s2_rem_d    = s2_step[8:0];
    end
  end

  angle_t             s2_start_q;
  logic signed [16:0] s2_diff_q;
  logic [8:0]         s2_rem_q, s2_div_q;
  logic               s2_nz_q;
  logic [5:0]         s2_quo_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[1]) begin
      s2_start_q <= s1_start_q;
      s2_diff_q  <= s1_diff_q;
      s2_rem_q   <= s2_rem_d;
      s2_div_q   <= s1_div_q;
      s2_nz_q    <= s1_nz_q;
      s2_quo_q   <= s2_quo_d;
    end
  end

  // stage 3: quotient bits 10..5
  logic [16:0] s2_xb;
  logic [8:0]  s3_rem_d;
  logic [5:0]  s3_quo_d;
  logic [9:0]  s3_step;

  assign s2_xb = {9'd0, s2_div_q[8:1]};

  always_comb begin
    s3_rem_d = s2_rem_q;
    s3_quo_d = '0;
    s3_step  = '0;
    for (int i = 0; i < 6; i++) begin
      s3_step     = div_step(s3_rem_d, s2_xb[10-i], s2_div_q);
      s3_quo_d[5-i] = s3_step[9];
      s3_rem_d    = s3_step[8:0];
    end
  end

  angle_t             s3_start_q;
  logic signed [16:0] s3_diff_q;
  logic [8:0]         s3_rem_q, s3_div_q;
  logic               s3_nz_q;
  logic [11:0]        s3_quo_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[2]) begin
      s3_start_q <= s2_start_q;
      s3_diff_q  <= s2_diff_q;
      s3_rem_q   <= s3_rem_d;
      s3_div_q   <= s2_div_q;
      s3_nz_q    <= s2_nz_q;
      s3_quo_q   <= {s2_quo_q, s3_quo_d};
    end
  end

  // stage 4: quotient bits 4..0, t in q1.16
  logic [16:0] s3_xb;
  logic [8:0]  s4_rem_d;
  logic [4:0]  s4_quo_d;
  logic [9:0]  s4_step;

  assign s3_xb = {9'd0, s3_div_q[8:1]};

  always_comb begin
    s4_rem_d = s3_rem_q;
    s4_quo_d = '0;
    s4_step  = '0;
    for (int i = 0; i < 5; i++) begin
      s4_step     = div_step(s4_rem_d, s3_xb[4-i], s3_div_q);
      s4_quo_d[4-i] = s4_step[9];
      s4_rem_d    = s4_step[8:0];
    end
  end

  angle_t             s4_start_q;
  logic signed [16:0] s4_diff_q;
  logic [16:0]        s4_t_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[3]) begin
      s4_start_q <= s3_start_q;
      s4_diff_q  <= s3_diff_q;
      s4_t_q     <= s3_nz_q ? {s3_quo_q, s4_quo_d} : 17'd0;
    end
  end

  // stage 5: t^2
  logic [33:0] s5_sq;

  assign s5_sq = 34'(s4_t_q) * 34'(s4_t_q) + 34'd32768;

  angle_t             s5_start_q;
  logic signed [16:0] s5_diff_q;
  logic [16:0]        s5_t_q, s5_t2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[4]) begin
      s5_start_q <= s4_start_q;
      s5_diff_q  <= s4_diff_q;
      s5_t_q     <= s4_t_q;
      s5_t2_q    <= s5_sq[32:16];
    end
  end

  // stage 6: t^3 and the quadratic factor
  logic [33:0] s6_cube;
  logic [20:0] s6_p;

  assign s6_cube = 34'(s5_t2_q) * 34'(s5_t_q) + 34'd32768;
  assign s6_p    = PBase + 21'(s5_t2_q) * 21'd6 - 21'(s5_t_q) * 21'd15;

  angle_t             s6_start_q;
  logic signed [16:0] s6_diff_q;
  logic [16:0]        s6_t3_q;
  logic [19:0]        s6_p_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[5]) begin
      s6_start_q <= s5_start_q;
      s6_diff_q  <= s5_diff_q;
      s6_t3_q    <= s6_cube[32:16];
      s6_p_q     <= s6_p[19:0];
    end
  end

  // stage 7: s = t^3 * p, clamped to one
  logic [37:0] s7_prod;
  logic [21:0] s7_sr;

  assign s7_prod = 38'(s6_t3_q) * 38'(s6_p_q) + 38'd32768;
  assign s7_sr   = s7_prod[37:16];

  angle_t             s7_start_q;
  logic signed [16:0] s7_diff_q;
  logic [16:0]        s7_s_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[6]) begin
      s7_start_q <= s6_start_q;
      s7_diff_q  <= s6_diff_q;
      s7_s_q     <= (s7_sr > 22'(TOne)) ? TOne : s7_sr[16:0];
    end
  end

  // stage 8: scale the angle span
  logic signed [34:0] s8_prod_d;

  assign s8_prod_d = 35'(s7_diff_q) * 35'($signed({1'b0, s7_s_q}));

  angle_t             s8_start_q;
  logic signed [34:0] s8_prod_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[7]) begin
      s8_start_q <= s7_start_q;
      s8_prod_q  <= s8_prod_d;
    end
  end

  // stage 9: round, offset, saturate
  logic signed [34:0] s9_rsum;
  logic signed [18:0] s9_delta;
  logic signed [19:0] s9_pos;
  angle_t             s9_sat;

  assign s9_rsum  = s8_prod_q + 35'sd32768;
  assign s9_delta = s9_rsum[34:16];
  assign s9_pos   = 20'(s8_start_q) + 20'(s9_delta);

  always_comb begin
    if (s9_pos > 20'sd32767) begin
      s9_sat = 16'sh7FFF;
    end else if (s9_pos < -20'sd32768) begin
      s9_sat = 16'sh8000;
    end else begin
      s9_sat = s9_pos[15:0];
    end
  end

  angle_t pos_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.take[8]) begin
      pos_q <= s9_sat;
    end
  end

  assign out_valid_o = ctrl.valid[8];
  assign position_o  = pos_q;

endmodule

/* tb/sv/tb_min_jerk_waypoint_unit.sv */
// ----------------------------------------------------------------------------
// tb_min_jerk_waypoint_unit
// Self-checking bench for the minimum-jerk waypoint unit. A short directed
// run covers angle extremes, clamped waypoints and the step count limits.
// Random beats then follow over several step counts. Both sides idle at
// random, and the receiver holds off for long spells so the pipeline backs
// up. Every output beat is compared with an in-bench integer model of the
// quintic profile.
// ----------------------------------------------------------------------------
module tb_min_jerk_waypoint_unit;
  import mjw_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 2 * NumStages + 4;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned PhaseBeats  = 150;

  class position_tracker;
    logic [7:0]  num_steps;
    angle_t      expected_q[$];
    int unsigned mismatches;

    function new();
      num_steps  = NumStepsRst;
      mismatches = 0;
    endfunction

    function angle_t predict_position(angle_t a0, angle_t a1, logic [7:0] idx);
      longint unsigned n, k, t, t2, t3, p, s;
      longint diff, delta, pos;
      n = (num_steps > MaxSteps) ? MaxSteps : num_steps;
      s = 0;
      if (n != 0) begin
        k  = (idx > n) ? n : idx;
        t  = ((k << 17) + n) / (2 * n);
        t2 = (t * t + 64'h8000) >> 16;
        t3 = (t2 * t + 64'h8000) >> 16;
        p  = PBase + 6 * t2 - 15 * t;
        s  = (t3 * p + 64'h8000) >> 16;
        if (s > TOne) s = TOne;
      end
      diff  = longint'(a1) - longint'(a0);
      delta = (diff * longint'(s) + 64'sh8000) >>> 16;
      pos   = longint'(a0) + delta;
      if (pos > 32767) pos = 32767;
      if (pos < -32768) pos = -32768;
      return angle_t'(pos);
    endfunction

    function void note_beat(angle_t a0, angle_t a1, logic [7:0] idx);
      expected_q = {expected_q, predict_position(a0, a1, idx)};
    endfunction

    function void check_beat(angle_t act);
      angle_t exp_pos;
      if (expected_q.size() == 0) begin
        $error("position beat with nothing expected, actual %0d", act);
        mismatches++;
        return;
      end
      exp_pos = expected_q.pop_front();
      if (act !== exp_pos) begin
        $error("position mismatch: expected %0d, actual %0d", exp_pos, act);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [7:0]  cfg_wdata_i      = '0;
  logic        in_valid_i       = 1'b0;
  angle_t      start_pos_i      = '0;
  angle_t      goal_pos_i       = '0;
  logic [7:0]  waypoint_index_i = '0;
  logic        out_stall_i      = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  angle_t      position_o;

  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned cycle_count = 0;

  position_tracker tracker;

  min_jerk_waypoint_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_pos_i      (start_pos_i),
    .goal_pos_i       (goal_pos_i),
    .waypoint_index_i (waypoint_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .position_o       (position_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_beat(position_o);
  end

  task automatic send_beat(input angle_t a0, input angle_t a1, input logic [7:0] idx);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    start_pos_i      <= a0;
    goal_pos_i       <= a1;
    waypoint_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_beat(a0, a1, idx);
  endtask

  task automatic send_random(input logic [7:0] steps);
    angle_t     a0, a1;
    logic [7:0] idx;
    case ($urandom_range(0, 3))
      0: begin
        a0 = angle_t'($urandom);
        a1 = angle_t'($urandom);
      end
      1: begin
        a0 = angle_t'($urandom);
        a1 = a0 + angle_t'($urandom_range(0, 511)) - angle_t'(256);
      end
      2: begin
        a0 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        a1 = ~a0;
      end
      default: begin
        a0 = angle_t'($urandom);
        a1 = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
    endcase
    if ($urandom_range(0, 4) != 0) idx = 8'($urandom_range(0, steps));
    else idx = 8'($urandom);
    send_beat(a0, a1, idx);
  endtask

  task automatic write_steps(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.num_steps = value;
  endtask

  // receiver: short random stalls, long hold-off on request
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      n = quiet ? 0 : $urandom_range(0, 3);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic [7:0] settings [8];
    settings = '{8'd40, 8'd1, 8'd255, 8'd0, 8'd3, 8'd170, 8'd85, 8'd12};
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset step count
    send_beat(16'sh8000, 16'sh7fff, 8'd0);
    send_beat(16'sh8000, 16'sh7fff, 8'd20);
    send_beat(16'sh8000, 16'sh7fff, 8'd40);
    send_beat(16'sh8000, 16'sh7fff, 8'd41);
    send_beat(16'sh8000, 16'sh7fff, 8'd255);
    send_beat(16'sh7fff, 16'sh8000, 8'd10);
    send_beat(16'sh7fff, 16'sh8000, 8'd30);
    send_beat(16'sh7fff, 16'sh8000, 8'd40);
    send_beat(16'sh0000, 16'sh0000, 8'd17);
    send_beat(16'sh1234, 16'sh1234, 8'd25);
    send_beat(16'sh0001, 16'shffff, 8'd20);
    // zero step count
    write_steps(8'd0);
    send_beat(16'sh03e8, 16'shfc18, 8'd0);
    send_beat(16'sh8000, 16'sh7fff, 8'd255);
    send_beat(16'sh7fff, 16'sh8000, 8'd1);
    // single interval
    write_steps(8'd1);
    send_beat(16'sh8000, 16'sh7fff, 8'd0);
    send_beat(16'sh8000, 16'sh7fff, 8'd1);
    send_beat(16'sh8000, 16'sh7fff, 8'd2);
    // largest step count
    write_steps(8'd255);
    send_beat(16'sh8000, 16'sh7fff, 8'd255);
    send_beat(16'sh8000, 16'sh7fff, 8'd128);
    send_beat(16'sh7fff, 16'sh8000, 8'd1);
    send_beat(16'sh8000, 16'sh7fff, 8'd254);

    settings[7] = 8'($urandom_range(2, 254));
    for (int ph = 0; ph < 8; ph++) begin
      write_steps(settings[ph]);
      quiet = (ph == 4);
      if (ph == 2 || ph == 5) hold_req = 1'b1;
      repeat (PhaseBeats) send_random(tracker.num_steps);
    end
    quiet = 1'b0;

    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mjw_pkg.sv
hw/rtl/mjw_pipe_ctrl.sv
hw/rtl/min_jerk_waypoint_unit.sv
tb/sv/tb_min_jerk_waypoint_unit.sv
